@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, sizes and codes for the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int DELAY_BITS  = 24;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_READ,
    ST_INS_CMP,
    ST_TK_READ,
    ST_TK_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   deadline;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // physical slot of logical position idx in the ring that starts at head
  function automatic logic [PTR_W-1:0] ring_slot(logic [PTR_W-1:0] head,
                                                 logic [CNT_W-1:0] idx);
    logic [CNT_W-1:0] sum;
    sum = {1'b0, head} + idx;
    if (sum >= CNT_W'(DEPTH)) begin
      sum = sum - CNT_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/stq_time_cmp.sv @@
// ----------------------------------------------------------------------------
// stq_time_cmp
// Wrap-aware deadline compare shared by insertion and expiry walks.
// ----------------------------------------------------------------------------
module stq_time_cmp import stq_pkg::*; (
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic                 early
);

  logic [TIME_BITS-1:0] diff;

  // a is earlier than b when a - b has its top bit set
  assign diff  = a - b;
  assign early = diff[TIME_BITS-1];

endmodule

@@ rtl/sorted_timer_event_queue.sv @@
// A schedule walks down from the tail, moving each later entry up a slot, and
// then writes the new one; on a full table it replies FULL without a walk. A
// tick advances time and pops every due entry from the head, holding one back
// so that the final reply carries last; out_ready stalls hold the walk.
// One request at a time: in_ready is high only while the sequencer is idle.
// Reset clears count, head, time and output valid; only occupied slots are read.
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Deadline-sorted event ring with insertion walk and expiry walk.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue import stq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [HANDLE_BITS-1:0] event_handle,
  input  logic [DELAY_BITS-1:0]  delay_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             kind,
  output logic [HANDLE_BITS-1:0] fired_handle,
  output logic                   last
);

  state_t state, state_next;

  logic [CNT_W-1:0]       count, count_next;
  logic [PTR_W-1:0]       head, head_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic [TIME_BITS-1:0]   cur_time, cur_time_next;
  logic [TIME_BITS-1:0]   new_deadline, new_deadline_next;
  logic                   pend_valid, pend_valid_next;
  logic [1:0]             pend_kind, pend_kind_next;
  logic [HANDLE_BITS-1:0] pend_handle, pend_handle_next;
  logic                   out_valid_next;
  logic [1:0]             kind_next;
  logic [HANDLE_BITS-1:0] fired_handle_next;
  logic                   last_next;

  entry_t           mem [DEPTH];
  entry_t           rd_entry;
  entry_t           mem_wdata;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;

  logic [TIME_BITS-1:0] cmp_a;
  logic                 early;
  logic                 out_free;

  assign out_free = !out_valid || out_ready;

  stq_time_cmp u_cmp (
    .a     (cmp_a),
    .b     (rd_entry.deadline),
    .early (early)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      head       <= '0;
      cur_time   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head       <= head_next;
      cur_time   <= cur_time_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx          <= idx_next;
    new_deadline <= new_deadline_next;
    pend_kind    <= pend_kind_next;
    pend_handle  <= pend_handle_next;
    kind         <= kind_next;
    fired_handle <= fired_handle_next;
    last         <= last_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    head_next         = head;
    idx_next          = idx;
    cur_time_next     = cur_time;
    new_deadline_next = new_deadline;
    pend_valid_next   = pend_valid;
    pend_kind_next    = pend_kind;
    pend_handle_next  = pend_handle;
    out_valid_next    = out_valid && !out_ready;
    kind_next         = kind;
    fired_handle_next = fired_handle;
    last_next         = last;
    mem_we            = 1'b0;
    mem_waddr         = ring_slot(head, idx);
    mem_wdata         = '{deadline: new_deadline, handle: pend_handle};
    mem_re            = 1'b0;
    mem_raddr         = head;
    cmp_a             = new_deadline;
    in_ready          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pend_handle_next = event_handle;
          if (op == OP_TICK) begin
            cur_time_next   = cur_time + TIME_BITS'(1);
            pend_valid_next = 1'b0;
            pend_kind_next  = KIND_EXPIRED;
            state_next      = ST_TK_READ;
          end else begin
            new_deadline_next = cur_time + TIME_BITS'(delay_ticks);
            idx_next          = count;
            if (count == CNT_W'(DEPTH)) begin
              pend_kind_next = KIND_FULL;
              state_next     = ST_EMIT;
            end else begin
              pend_kind_next = KIND_ACCEPTED;
              state_next     = ST_INS_READ;
            end
          end
        end
      end

      ST_INS_READ: begin
        if (idx == '0) begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = ST_EMIT;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = ring_slot(head, idx - CNT_W'(1));
          state_next = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (early) begin
          // new entry is strictly earlier: move the older one up a slot
          mem_wdata  = rd_entry;
          idx_next   = idx - CNT_W'(1);
          state_next = ST_INS_READ;
        end else begin
          count_next = count + CNT_W'(1);
          state_next = ST_EMIT;
        end
      end

      ST_TK_READ: begin
        if (count == '0) begin
          state_next = pend_valid ? ST_EMIT : ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = head;
          state_next = ST_TK_CMP;
        end
      end

      ST_TK_CMP: begin
        cmp_a = cur_time;
        if (!early) begin
          // head entry is due; the held one is not the last
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid_next    = 1'b1;
              kind_next         = KIND_EXPIRED;
              fired_handle_next = pend_handle;
              last_next         = 1'b0;
            end
            pend_handle_next = rd_entry.handle;
            pend_valid_next  = 1'b1;
            head_next        = ring_slot(head, CNT_W'(1));
            count_next       = count - CNT_W'(1);
            state_next       = ST_TK_READ;
          end
        end else begin
          state_next = pend_valid ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_next    = 1'b1;
          kind_next         = pend_kind;
          fired_handle_next = pend_handle;
          last_next         = 1'b1;
          pend_valid_next   = 1'b0;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < CNT_W'(DEPTH))
    else $error("ring head out of range");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == OP_TICK) |=>
      cur_time == $past(cur_time) + TIME_BITS'(1))
    else $error("tick did not advance time");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && pend_kind == KIND_FULL) |-> count == CNT_W'(DEPTH))
    else $error("reject issued while table has room");

  a_insert_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_CMP) |-> (idx != '0 && count != CNT_W'(DEPTH)))
    else $error("insertion compare at invalid position");
`endif

endmodule
